// ===== hdl/pivr_pkg.sv =====
// Shared types and constants of the PI velocity regulator.
package pivr_pkg;

  // Q0.32 time step width and the divider that produces it
  localparam int TS_W              = 32;
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS         = TS_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 8'd3;

  localparam logic [31:0] PROP_GAIN_RST   = 32'd5243;
  localparam logic [31:0] INTEG_GAIN_RST  = 32'd6554;
  localparam logic [30:0] RAMP_LIMIT_RST  = 31'd6553600;
  localparam logic [30:0] DRIVE_LIMIT_RST = 31'd786432;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICKS,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_ALO,
    ST_MUL_AHI,
    ST_MUL_RAMP,
    ST_INTEG,
    ST_SUM,
    ST_DELTA,
    ST_OUT
  } ctrl_state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICKS,
    OP_DIV,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_ALO,
    OP_MUL_AHI,
    OP_MUL_RAMP,
    OP_INTEG,
    OP_SUM,
    OP_DELTA,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load;   // latch the accepted input word
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free; // output register can take a word this cycle
    logic out_busy; // output register holds a word
  } dp_status_t;

endpackage

// ===== hdl/pi_velocity_regulator_with_ramp_top.sv =====
// Top level of the PI velocity regulator with output slope limit.
//
// Each input word carries a signed Q16.16 velocity error and the present
// value of a down-counting tick timer. The block derives the time step from
// the tick difference, forms the proportional term and a trapezoidal
// integral, clamps the integral and the sum to +-drive_limit, limits the
// output slope to ramp_limit per second and returns one signed Q16.16
// drive word. A word is taken when in_tvalid and in_tready are high; a
// result leaves when out_tvalid and out_tready are high. Gains and limits
// are written through cfg_we / cfg_index / cfg_wdata while no word is in
// flight; the user must keep to this, as the block does not enforce it. A new
// word is taken only once the last one has left its final step. The time step
// divider produces two quotient bits a cycle; five passes through the one
// shared multiplier and four add/clamp steps follow.
// Reset (rst_n low, synchronous) clears the integral, previous error, previous
// output and previous tick to zero and loads the default gains and limits.
// A stalled receiver holds the result in the output register; the next word
// is still accepted and processed up to its last step, which waits there
// until the output register is free.
module pi_velocity_regulator_with_ramp_top #(
  parameter int  TICKS_PER_US = 9,
  parameter int  TIMER_BITS   = 24,
  localparam int IN_W         = ((32 + TIMER_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // speed_error, tick_now, zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // drive_out
  input  logic                            cfg_we,
  input  logic [pivr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pivr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0] prop_gain_r, prop_gain_nxt;
  logic [31:0] integ_gain_r, integ_gain_nxt;
  logic [30:0] ramp_limit_r, ramp_limit_nxt;
  logic [30:0] drive_limit_r, drive_limit_nxt;

  pivr_pkg::dp_cmd_t    cmd;
  pivr_pkg::dp_status_t status;
  logic signed [31:0]   drive_out;

  // Decode register writes
  always_comb begin
    prop_gain_nxt   = prop_gain_r;
    integ_gain_nxt  = integ_gain_r;
    ramp_limit_nxt  = ramp_limit_r;
    drive_limit_nxt = drive_limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pivr_pkg::REG_PROP_GAIN:   prop_gain_nxt   = cfg_wdata;
        pivr_pkg::REG_INTEG_GAIN:  integ_gain_nxt  = cfg_wdata;
        pivr_pkg::REG_RAMP_LIMIT:  ramp_limit_nxt  = cfg_wdata[30:0];
        pivr_pkg::REG_DRIVE_LIMIT: drive_limit_nxt = cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= pivr_pkg::PROP_GAIN_RST;
      integ_gain_r  <= pivr_pkg::INTEG_GAIN_RST;
      ramp_limit_r  <= pivr_pkg::RAMP_LIMIT_RST;
      drive_limit_r <= pivr_pkg::DRIVE_LIMIT_RST;
    end else begin
      prop_gain_r   <= prop_gain_nxt;
      integ_gain_r  <= integ_gain_nxt;
      ramp_limit_r  <= ramp_limit_nxt;
      drive_limit_r <= drive_limit_nxt;
    end
  end

  pivr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pivr_dp #(
    .TICKS_PER_US (TICKS_PER_US),
    .TIMER_BITS   (TIMER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .speed_error (signed'(in_tdata[31:0])),
    .tick_now    (in_tdata[32 +: TIMER_BITS]),
    .prop_gain   (prop_gain_r),
    .integ_gain  (integ_gain_r),
    .ramp_limit  (ramp_limit_r),
    .drive_limit (drive_limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .drive_out   (drive_out)
  );

  assign out_tdata = drive_out;

endmodule

// ===== hdl/pivr_ctrl.sv =====
// Sequencer of the PI velocity regulator: steps the datapath through one update.
module pivr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  pivr_pkg::dp_status_t status,
  output pivr_pkg::dp_cmd_t    cmd
);

  pivr_pkg::ctrl_state_t state_r, state_nxt;
  logic [pivr_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pivr_pkg::ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.op      = pivr_pkg::OP_NONE;
    unique case (state_r)
      pivr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = pivr_pkg::ST_TICKS;
        end
      end
      pivr_pkg::ST_TICKS: begin
        cmd.op      = pivr_pkg::OP_TICKS;
        div_cnt_nxt = '0;
        state_nxt   = pivr_pkg::ST_DIV;
      end
      pivr_pkg::ST_DIV: begin
        cmd.op      = pivr_pkg::OP_DIV;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == pivr_pkg::DIV_CNT_W'(pivr_pkg::DIV_STEPS - 1)) begin
          state_nxt = pivr_pkg::ST_MUL_P;
        end
      end
      pivr_pkg::ST_MUL_P: begin
        cmd.op    = pivr_pkg::OP_MUL_P;
        state_nxt = pivr_pkg::ST_MUL_I;
      end
      pivr_pkg::ST_MUL_I: begin
        cmd.op    = pivr_pkg::OP_MUL_I;
        state_nxt = pivr_pkg::ST_MUL_ALO;
      end
      pivr_pkg::ST_MUL_ALO: begin
        cmd.op    = pivr_pkg::OP_MUL_ALO;
        state_nxt = pivr_pkg::ST_MUL_AHI;
      end
      pivr_pkg::ST_MUL_AHI: begin
        cmd.op    = pivr_pkg::OP_MUL_AHI;
        state_nxt = pivr_pkg::ST_MUL_RAMP;
      end
      pivr_pkg::ST_MUL_RAMP: begin
        cmd.op    = pivr_pkg::OP_MUL_RAMP;
        state_nxt = pivr_pkg::ST_INTEG;
      end
      pivr_pkg::ST_INTEG: begin
        cmd.op    = pivr_pkg::OP_INTEG;
        state_nxt = pivr_pkg::ST_SUM;
      end
      pivr_pkg::ST_SUM: begin
        cmd.op    = pivr_pkg::OP_SUM;
        state_nxt = pivr_pkg::ST_DELTA;
      end
      pivr_pkg::ST_DELTA: begin
        cmd.op    = pivr_pkg::OP_DELTA;
        state_nxt = pivr_pkg::ST_OUT;
      end
      pivr_pkg::ST_OUT: begin
        // hold until the output register frees up
        if (status.out_free) begin
          cmd.op    = pivr_pkg::OP_OUT;
          state_nxt = pivr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pivr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pivr_dp.sv =====
// Datapath of the PI velocity regulator: time step divider, shared multiplier,
// clamps, slope limit, loop state and output register.
module pivr_dp #(
  parameter int TICKS_PER_US = 9,
  parameter int TIMER_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pivr_pkg::dp_cmd_t     cmd,
  output pivr_pkg::dp_status_t  status,
  input  logic signed [31:0]    speed_error,
  input  logic [TIMER_BITS-1:0] tick_now,
  input  logic [31:0]           prop_gain,
  input  logic [31:0]           integ_gain,
  input  logic [30:0]           ramp_limit,
  input  logic [30:0]           drive_limit,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic signed [31:0]    drive_out
);

  localparam int          TS_W    = pivr_pkg::TS_W;
  localparam int unsigned DIVISOR = TICKS_PER_US * 1000000;
  localparam int          DW      = $clog2(DIVISOR) + 1;
  localparam int          RAW_W   = TIMER_BITS + 1;

  localparam logic [DW-1:0]         DIV_C  = DW'(DIVISOR);
  localparam logic [33:0]           N_MAX  = 34'(500000 * TICKS_PER_US);
  localparam logic [33:0]           N_DEF  = 34'(1000 * TICKS_PER_US);
  localparam logic [TIMER_BITS-1:0] T_MASK = '1;

  // Clamp a wide signed value to +-lim
  function automatic logic signed [31:0] clamp_sym(input logic signed [48:0] v,
                                                   input logic [30:0] lim);
    logic signed [48:0] hi;
    hi = signed'({18'b0, lim});
    if (v > hi) begin
      return 32'(hi);
    end else if (v < -hi) begin
      return 32'(-hi);
    end
    return 32'(v);
  endfunction

  // Input word
  logic signed [31:0]    err_r, err_nxt;
  logic [TIMER_BITS-1:0] now_r, now_nxt;
  // Loop state
  logic signed [31:0]    integ_acc_r, integ_acc_nxt;
  logic signed [31:0]    last_err_r, last_err_nxt;
  logic signed [31:0]    last_out_r, last_out_nxt;
  logic [TIMER_BITS-1:0] last_tick_r, last_tick_nxt;
  // Operands
  logic [31:0]           err_mag_r, err_mag_nxt;
  logic                  err_neg_r, err_neg_nxt;
  logic [32:0]           esum_mag_r, esum_mag_nxt;
  logic                  esum_neg_r, esum_neg_nxt;
  // Divider
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [TS_W-1:0]       ts_r, ts_nxt;
  // Multiplier and partial results
  logic [63:0]           prod_r, prod_nxt;
  logic [31:0]           a_hi_r, a_hi_nxt;
  logic [63:0]           lo_r, lo_nxt;
  logic [46:0]           imag_r, imag_nxt;
  logic signed [48:0]    prop_s_r, prop_s_nxt;
  logic [30:0]           step_r, step_nxt;
  logic signed [31:0]    integ_r, integ_nxt;
  logic signed [31:0]    sum_r, sum_nxt;
  logic signed [32:0]    delta_r, delta_nxt;
  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    out_data_r, out_data_nxt;

  logic [32:0]           op_a;
  logic [31:0]           op_b;
  logic [63:0]           mul_prod;

  // Elapsed ticks
  logic [RAW_W-1:0]      raw_n;
  logic                  n_ok;
  // Tustin error sum
  logic signed [32:0]    esum;
  // Integral increment alignment
  logic [95:0]           imag_full;
  // Slope limit
  logic signed [33:0]    step_s;
  logic signed [33:0]    delta_x;
  logic signed [33:0]    res_up;
  logic signed [33:0]    res_dn;
  // Divider steps
  logic [DW-1:0]         div_rem;
  logic [TS_W-1:0]       div_q;
  logic [DW-1:0]         div_sh;
  logic                  div_ge;

  assign status.out_free = !out_valid_r || out_tready;
  assign status.out_busy = out_valid_r;
  assign out_tvalid      = out_valid_r;
  assign drive_out       = out_data_r;

  // Shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      pivr_pkg::OP_MUL_P: begin
        op_a = {1'b0, err_mag_r};
        op_b = prop_gain;
      end
      pivr_pkg::OP_MUL_I: begin
        op_a = esum_mag_r;
        op_b = integ_gain;
      end
      pivr_pkg::OP_MUL_ALO: begin
        op_a = {1'b0, prod_r[31:0]};
        op_b = ts_r;
      end
      pivr_pkg::OP_MUL_AHI: begin
        op_a = {1'b0, a_hi_r};
        op_b = ts_r;
      end
      pivr_pkg::OP_MUL_RAMP: begin
        op_a = {2'b0, ramp_limit};
        op_b = ts_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_prod = {31'b0, op_a} * {32'b0, op_b};

  // Elapsed ticks since the previous word, with wrap
  always_comb begin
    if (now_r < last_tick_r) begin
      raw_n = {1'b0, last_tick_r} - {1'b0, now_r};
    end else begin
      raw_n = {1'b0, T_MASK} - {1'b0, now_r} + {1'b0, last_tick_r};
    end
    n_ok = (raw_n != '0) && (34'(raw_n) <= N_MAX);
  end

  assign esum      = {err_r[31], err_r} + {last_err_r[31], last_err_r};
  assign imag_full = {prod_r, 32'b0} + {32'b0, lo_r};
  assign step_s    = signed'({3'b0, step_r});
  assign delta_x   = 34'(delta_r);
  assign res_up    = 34'(last_out_r) + step_s;
  assign res_dn    = 34'(last_out_r) - step_s;

  // Restoring division, DIV_BITS_PER_STEP quotient bits per cycle
  always_comb begin
    div_rem = rem_r;
    div_q   = ts_r;
    div_sh  = '0;
    div_ge  = 1'b0;
    for (int i = 0; i < pivr_pkg::DIV_BITS_PER_STEP; i++) begin
      div_sh  = {div_rem[DW-2:0], 1'b0};
      div_ge  = div_sh >= DIV_C;
      div_rem = div_ge ? div_sh - DIV_C : div_sh;
      div_q   = {div_q[TS_W-2:0], div_ge};
    end
  end

  // Next values per operation
  always_comb begin
    err_nxt       = err_r;
    now_nxt       = now_r;
    integ_acc_nxt = integ_acc_r;
    last_err_nxt  = last_err_r;
    last_out_nxt  = last_out_r;
    last_tick_nxt = last_tick_r;
    err_mag_nxt   = err_mag_r;
    err_neg_nxt   = err_neg_r;
    esum_mag_nxt  = esum_mag_r;
    esum_neg_nxt  = esum_neg_r;
    rem_nxt       = rem_r;
    ts_nxt        = ts_r;
    prod_nxt      = prod_r;
    a_hi_nxt      = a_hi_r;
    lo_nxt        = lo_r;
    imag_nxt      = imag_r;
    prop_s_nxt    = prop_s_r;
    step_nxt      = step_r;
    integ_nxt     = integ_r;
    sum_nxt       = sum_r;
    delta_nxt     = delta_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    // latch the accepted word
    if (cmd.load) begin
      err_nxt = speed_error;
      now_nxt = tick_now;
    end

    unique case (cmd.op)
      pivr_pkg::OP_NONE: begin
      end
      pivr_pkg::OP_TICKS: begin
        // pick the step in ticks and prepare operand magnitudes
        rem_nxt       = n_ok ? DW'(raw_n) : DW'(N_DEF);
        ts_nxt        = '0;
        last_tick_nxt = now_r;
        err_neg_nxt   = err_r[31];
        err_mag_nxt   = err_r[31] ? 32'(-err_r) : 32'(err_r);
        esum_neg_nxt  = esum[32];
        esum_mag_nxt  = esum[32] ? 33'(-esum) : 33'(esum);
      end
      pivr_pkg::OP_DIV: begin
        rem_nxt = div_rem;
        ts_nxt  = div_q;
      end
      pivr_pkg::OP_MUL_P: begin
        prod_nxt = mul_prod;
      end
      pivr_pkg::OP_MUL_I: begin
        // proportional term, truncated toward zero
        prod_nxt   = mul_prod;
        prop_s_nxt = err_neg_r ? -signed'({1'b0, prod_r[63:16]})
                               : signed'({1'b0, prod_r[63:16]});
      end
      pivr_pkg::OP_MUL_ALO: begin
        prod_nxt = mul_prod;
        a_hi_nxt = prod_r[63:32];
      end
      pivr_pkg::OP_MUL_AHI: begin
        prod_nxt = mul_prod;
        lo_nxt   = prod_r;
      end
      pivr_pkg::OP_MUL_RAMP: begin
        // integral increment magnitude: product over 2^49
        prod_nxt = mul_prod;
        imag_nxt = imag_full[95:49];
      end
      pivr_pkg::OP_INTEG: begin
        step_nxt = prod_r[62:32];
        if (esum_neg_r) begin
          integ_nxt = clamp_sym(49'(integ_acc_r) - signed'({2'b0, imag_r}), drive_limit);
        end else begin
          integ_nxt = clamp_sym(49'(integ_acc_r) + signed'({2'b0, imag_r}), drive_limit);
        end
      end
      pivr_pkg::OP_SUM: begin
        sum_nxt = clamp_sym(prop_s_r + 49'(integ_r), drive_limit);
      end
      pivr_pkg::OP_DELTA: begin
        delta_nxt = 33'(sum_r) - 33'(last_out_r);
      end
      pivr_pkg::OP_OUT: begin
        // limit the slope, emit and advance the loop state
        if (delta_x > step_s) begin
          out_data_nxt = 32'(res_up);
        end else if (delta_x < -step_s) begin
          out_data_nxt = 32'(res_dn);
        end else begin
          out_data_nxt = sum_r;
        end
        last_out_nxt  = out_data_nxt;
        integ_acc_nxt = integ_r;
        last_err_nxt  = err_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      integ_acc_r <= '0;
      last_err_r  <= '0;
      last_out_r  <= '0;
      last_tick_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      integ_acc_r <= integ_acc_nxt;
      last_err_r  <= last_err_nxt;
      last_out_r  <= last_out_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    now_r      <= now_nxt;
    err_mag_r  <= err_mag_nxt;
    err_neg_r  <= err_neg_nxt;
    esum_mag_r <= esum_mag_nxt;
    esum_neg_r <= esum_neg_nxt;
    rem_r      <= rem_nxt;
    ts_r       <= ts_nxt;
    prod_r     <= prod_nxt;
    a_hi_r     <= a_hi_nxt;
    lo_r       <= lo_nxt;
    imag_r     <= imag_nxt;
    prop_s_r   <= prop_s_nxt;
    step_r     <= step_nxt;
    integ_r    <= integ_nxt;
    sum_r      <= sum_nxt;
    delta_r    <= delta_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
